// ===== hdl/dda_pkg.sv =====
// Shared types for the DDA line rasterizer: controller states and the
// command and status structs that pass between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package dda_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic advance;
    } t_dp_cmd;

    typedef struct packed {
        logic steps_zero;
        logic last;
    } t_dp_status;

endpackage

// ===== hdl/dda_if.sv =====
// Valid/ready channel interfaces for the line request and the pixel stream.
// No dependencies.
`timescale 1ns / 1ps

interface dda_line_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface dda_pixel_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

// ===== hdl/dda_line_rasterizer_core.sv =====
// Top level of the DDA line rasterizer: joins the controller and datapath
// to the line request and pixel stream channels.
// Depends on dda_pkg, dda_if, dda_ctrl and dda_dp.
//
//  channel   dir  modport  payload
//  i_line    in   sink     start_x, start_y, end_x, end_y (COORD_BITS each)
//  o_pixel   out  source   pixel_x, pixel_y (COORD_BITS each), last_pixel
//
// A line is accepted in ST_IDLE, divided in ST_DIV (no division steps for a
// zero-length line) and then leaves as steps + 1 pixel transactions.
// The divider retires one quotient bit per cycle for both axes at once.
// One line is in flight at a time; i_line.ready is high only when idle.
// Back-pressure on o_pixel holds the current pixel. Reset is synchronous,
// active low, and returns the controller to idle.
`timescale 1ns / 1ps

module dda_line_rasterizer_core #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    dda_line_if.sink     i_line,
    dda_pixel_if.source  o_pixel
);

    dda_pkg::t_dp_cmd      cmd;
    dda_pkg::t_dp_status   status;
    logic [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
    logic [COORD_BITS-1:0] pixel_x, pixel_y;
    logic                  last_pixel;
    logic                  in_ready, out_valid;

    assign start_x = i_line.start_x;
    assign start_y = i_line.start_y;
    assign end_x   = i_line.end_x;
    assign end_y   = i_line.end_y;

    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_line.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_pixel.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    dda_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_start_x    (start_x),
        .i_start_y    (start_y),
        .i_end_x      (end_x),
        .i_end_y      (end_y),
        .o_pixel_x    (pixel_x),
        .o_pixel_y    (pixel_y),
        .o_last_pixel (last_pixel)
    );

    assign i_line.ready       = in_ready;
    assign o_pixel.valid      = out_valid;
    assign o_pixel.pixel_x    = pixel_x;
    assign o_pixel.pixel_y    = pixel_y;
    assign o_pixel.last_pixel = last_pixel;

`ifndef SYNTHESIS
    // No new line while a pixel is on offer.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid))
        else $error("line accepted while a pixel is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_line.valid && in_ready) |=> !in_ready)
        else $error("ready did not drop after a line transaction");

    a_stream_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_pixel.ready && !last_pixel) |=> out_valid)
        else $error("pixel stream broke before the last pixel");

    a_stream_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && o_pixel.ready && last_pixel) |=> (!out_valid && in_ready))
        else $error("block did not return to idle after the last pixel");
`endif

endmodule

// ===== hdl/dda_dp.sv =====
// Datapath of the DDA line rasterizer: step count, two restoring dividers
// that run one quotient bit per cycle, and the fixed-point accumulators.
// Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_dp #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                    i_clk,
    input  dda_pkg::t_dp_cmd        i_cmd,
    output dda_pkg::t_dp_status     o_status,
    input  logic [COORD_BITS-1:0]   i_start_x,
    input  logic [COORD_BITS-1:0]   i_start_y,
    input  logic [COORD_BITS-1:0]   i_end_x,
    input  logic [COORD_BITS-1:0]   i_end_y,
    output logic [COORD_BITS-1:0]   o_pixel_x,
    output logic [COORD_BITS-1:0]   o_pixel_y,
    output logic                    o_last_pixel
);

    localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int R_W   = COORD_BITS + 1;
    localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

    logic [ACC_W-1:0]      r_acc_x, r_acc_y;
    logic                  r_neg_x, r_neg_y;
    logic [R_W-1:0]        r_rem_x, r_rem_y;
    logic [Q_W-1:0]        r_q_x, r_q_y;
    logic [COORD_BITS-1:0] r_steps;
    logic [COORD_BITS-1:0] r_left;

    logic [R_W-1:0]        dx, dy;
    logic [R_W-1:0]        abs_dx, abs_dy;
    logic [COORD_BITS-1:0] mag_x, mag_y, steps;
    logic [R_W-1:0]        steps_ext;
    logic                  ge_x, ge_y;
    logic [R_W-1:0]        diff_x, diff_y;
    logic [ACC_W-1:0]      inc_x, inc_y;

    // Signed differences carry one extra bit; the magnitude always fits
    // back into COORD_BITS.
    always_comb begin
        dx     = {1'b0, i_end_x} - {1'b0, i_start_x};
        dy     = {1'b0, i_end_y} - {1'b0, i_start_y};
        abs_dx = dx[R_W-1] ? (~dx + 1'b1) : dx;
        abs_dy = dy[R_W-1] ? (~dy + 1'b1) : dy;
        mag_x  = abs_dx[COORD_BITS-1:0];
        mag_y  = abs_dy[COORD_BITS-1:0];
        steps  = (mag_x > mag_y) ? mag_x : mag_y;
    end

    // Since each magnitude is at most the step count, the quotient is
    // one integer bit and FRAC_BITS fraction bits.
    always_comb begin
        steps_ext = {1'b0, r_steps};
        ge_x      = r_rem_x >= steps_ext;
        ge_y      = r_rem_y >= steps_ext;
        diff_x    = ge_x ? (r_rem_x - steps_ext) : r_rem_x;
        diff_y    = ge_y ? (r_rem_y - steps_ext) : r_rem_y;
        inc_x     = {{(ACC_W-Q_W){1'b0}}, r_q_x};
        inc_y     = {{(ACC_W-Q_W){1'b0}}, r_q_y};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_acc_x <= {1'b0, i_start_x, {FRAC_BITS{1'b0}}} | HALF;
            r_acc_y <= {1'b0, i_start_y, {FRAC_BITS{1'b0}}} | HALF;
            r_neg_x <= dx[R_W-1];
            r_neg_y <= dy[R_W-1];
            r_rem_x <= {1'b0, mag_x};
            r_rem_y <= {1'b0, mag_y};
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_steps <= steps;
            r_left  <= steps;
        end else if (i_cmd.div_step) begin
            r_rem_x <= {diff_x[R_W-2:0], 1'b0};
            r_rem_y <= {diff_y[R_W-2:0], 1'b0};
            r_q_x   <= {r_q_x[Q_W-2:0], ge_x};
            r_q_y   <= {r_q_y[Q_W-2:0], ge_y};
        end else if (i_cmd.advance) begin
            r_acc_x <= r_neg_x ? (r_acc_x - inc_x) : (r_acc_x + inc_x);
            r_acc_y <= r_neg_y ? (r_acc_y - inc_y) : (r_acc_y + inc_y);
            r_left  <= r_left - 1'b1;
        end
    end

    // The accumulators already hold the rounding offset, so the pixel is
    // a plain bit-select.
    assign o_pixel_x           = r_acc_x[FRAC_BITS +: COORD_BITS];
    assign o_pixel_y           = r_acc_y[FRAC_BITS +: COORD_BITS];
    assign o_last_pixel        = (r_left == '0);
    assign o_status.last       = (r_left == '0);
    assign o_status.steps_zero = (r_steps == '0);

endmodule

// ===== hdl/dda_ctrl.sv =====
// Controller of the DDA line rasterizer: accepts a line, sequences the
// division and then steps + 1 pixel transactions.
// Depends on dda_pkg.
`timescale 1ns / 1ps

module dda_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dda_pkg::t_dp_status i_status,
    output dda_pkg::t_dp_cmd    o_cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS);

    dda_pkg::t_state  r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dda_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dda_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = dda_pkg::ST_DIV;
            end
            dda_pkg::ST_DIV: begin
                if (i_status.steps_zero || r_cnt == DIV_LAST) n_state = dda_pkg::ST_EMIT;
            end
            dda_pkg::ST_EMIT: begin
                if (i_out_ready && i_status.last) n_state = dda_pkg::ST_IDLE;
            end
            default: n_state = dda_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.div_step = 1'b0;
        o_cmd.advance  = 1'b0;
        n_cnt          = r_cnt;
        unique case (r_state)
            dda_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_cnt      = '0;
            end
            dda_pkg::ST_DIV: begin
                // A zero-length line keeps its cleared increments.
                o_cmd.div_step = !i_status.steps_zero;
                n_cnt          = r_cnt + 1'b1;
            end
            dda_pkg::ST_EMIT: begin
                o_out_valid   = 1'b1;
                o_cmd.advance = i_out_ready && !i_status.last;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for dda_line_rasterizer_core: a directed table of lines,
// then random lines, checked pixel by pixel against a stored pixel or an in-bench tracer.
// Depends on dda_if (line and pixel channels) and the rasterizer RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int COORD_BITS = 6;
    localparam int FRAC_BITS  = 16;
    localparam int HALF_LSB   = 1 << (FRAC_BITS - 1);
    localparam int N_RANDOM   = 98;
    localparam int DRAIN_CYC  = 2 * (FRAC_BITS + 2);

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_line;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    // A row with a known answer carries the single pixel it must produce.
    typedef struct packed {
        t_line  ln;
        logic   known;
        t_pixel px;
    } t_vector;

    logic i_clk;
    logic i_rst_n;

    dda_line_if  #(.COORD_BITS(COORD_BITS)) line_ch ();
    dda_pixel_if #(.COORD_BITS(COORD_BITS)) pix_ch ();

    dda_line_rasterizer_core #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_line (line_ch.sink),
        .o_pixel(pix_ch.source)
    );

    t_pixel      plot_q[$];
    int unsigned fails = 0;
    bit          calm  = 1'b0;

    t_vector dir_tab [22] = '{
        '{'{6'd0,  6'd0,  6'd0,  6'd0},  1'b1, '{6'd0,  6'd0,  1'b1}},
        '{'{6'd63, 6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 6'd63, 1'b1}},
        '{'{6'd21, 6'd42, 6'd21, 6'd42}, 1'b1, '{6'd21, 6'd42, 1'b1}},
        '{'{6'd0,  6'd0,  6'd63, 6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd63, 6'd0,  6'd0,  6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd0,  6'd0,  6'd63}, 1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd63, 6'd0,  6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd0,  6'd63, 6'd63}, 1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd63, 6'd63, 6'd0,  6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd63, 6'd0,  6'd0,  6'd63}, 1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd63, 6'd63, 6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd0,  6'd2,  6'd1},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd1,  6'd2,  6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd0,  6'd63, 6'd1},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd0,  6'd1,  6'd63, 6'd0},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd5,  6'd5,  6'd6,  6'd5},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd5,  6'd5,  6'd4,  6'd6},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd10, 6'd20, 6'd13, 6'd62}, 1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd42, 6'd21, 6'd7,  6'd28}, 1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd1,  6'd2,  6'd3,  6'd4},  1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd62, 6'd1,  6'd1,  6'd62}, 1'b0, '{6'd0,  6'd0,  1'b0}},
        '{'{6'd32, 6'd31, 6'd31, 6'd32}, 1'b0, '{6'd0,  6'd0,  1'b0}}
    };

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #10_000_000;
        $display("tb_top failed");
        $finish;
    end

    function automatic int unsigned draw_wait();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // Traces the line in 16-bit fraction fixed point and queues every pixel it plots.
    function automatic void trace_line(t_line ln);
        int     dx, dy, adx, ady, steps, xinc, yinc, ax, ay, rx, ry;
        t_pixel px;
        dx    = int'(ln.end_x) - int'(ln.start_x);
        dy    = int'(ln.end_y) - int'(ln.start_y);
        adx   = (dx < 0) ? -dx : dx;
        ady   = (dy < 0) ? -dy : dy;
        steps = (adx > ady) ? adx : ady;
        xinc  = 0;
        yinc  = 0;
        if (steps != 0) begin
            // The magnitude is divided, so the quotient rounds toward zero.
            xinc = (adx << FRAC_BITS) / steps;
            yinc = (ady << FRAC_BITS) / steps;
            if (dx < 0) xinc = -xinc;
            if (dy < 0) yinc = -yinc;
        end
        ax = int'(ln.start_x) << FRAC_BITS;
        ay = int'(ln.start_y) << FRAC_BITS;
        for (int i = 0; i <= steps; i++) begin
            rx      = (ax + HALF_LSB) >>> FRAC_BITS;
            ry      = (ay + HALF_LSB) >>> FRAC_BITS;
            px.x    = rx[COORD_BITS-1:0];
            px.y    = ry[COORD_BITS-1:0];
            px.last = (i == steps);
            plot_q.push_back(px);
            ax += xinc;
            ay += yinc;
        end
    endfunction

    // Offers one line and returns at the edge where the transaction completes.
    task automatic send_line(input t_line ln, input logic known, input t_pixel px);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            line_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        line_ch.valid   <= 1'b1;
        line_ch.start_x <= ln.start_x;
        line_ch.start_y <= ln.start_y;
        line_ch.end_x   <= ln.end_x;
        line_ch.end_y   <= ln.end_y;
        do @(posedge i_clk); while (line_ch.ready !== 1'b1);
        if (known) plot_q.push_back(px);
        else trace_line(ln);
    endtask

    // Holds the sender back until the block has handed over every pixel owed.
    task automatic wait_drained();
        line_ch.valid <= 1'b0;
        do @(posedge i_clk); while (plot_q.size() != 0);
    endtask

    task automatic check_pixel();
        t_pixel want;
        if (plot_q.size() == 0) begin
            $error("unexpected pixel x=%0d y=%0d last=%0d",
                   pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last_pixel);
            fails++;
        end else begin
            want = plot_q.pop_front();
            if (pix_ch.pixel_x !== want.x) begin
                $error("pixel_x: expected %0d, got %0d", want.x, pix_ch.pixel_x);
                fails++;
            end
            if (pix_ch.pixel_y !== want.y) begin
                $error("pixel_y: expected %0d, got %0d", want.y, pix_ch.pixel_y);
                fails++;
            end
            if (pix_ch.last_pixel !== want.last) begin
                $error("last_pixel: expected %0d, got %0d", want.last, pix_ch.last_pixel);
                fails++;
            end
        end
    endtask

    // Pixel receiver: checks each transaction and then stalls for a drawn number of cycles.
    initial begin
        int unsigned rx_wait;
        rx_wait = 0;
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1) begin
                check_pixel();
                rx_wait = draw_wait();
            end
            if (rx_wait != 0) begin
                pix_ch.ready <= 1'b0;
                rx_wait--;
            end else begin
                pix_ch.ready <= 1'b1;
            end
        end
    end

    // Line sender: the directed table first, then random lines.
    initial begin
        t_line       ln;
        t_pixel      none;
        int unsigned waited;
        none = '0;
        line_ch.valid   <= 1'b0;
        line_ch.start_x <= '0;
        line_ch.start_y <= '0;
        line_ch.end_x   <= '0;
        line_ch.end_y   <= '0;
        repeat (10) @(posedge i_clk);

        foreach (dir_tab[i]) send_line(dir_tab[i].ln, dir_tab[i].known, dir_tab[i].px);
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 10 == 0) calm = ($urandom_range(0, 2) == 0);
            ln.start_x = t_coord'($urandom());
            ln.start_y = t_coord'($urandom());
            ln.end_x   = t_coord'($urandom());
            ln.end_y   = t_coord'($urandom());
            case ($urandom_range(0, 7))
                0: begin
                    ln.end_x = ln.start_x;
                    ln.end_y = ln.start_y;
                end
                1: begin
                    if ($urandom_range(0, 1) == 0) ln.end_x = ln.start_x;
                    else ln.end_y = ln.start_y;
                end
                2, 3: begin
                    // Short lines in any direction.
                    ln.end_x = ln.start_x ^ t_coord'($urandom_range(0, 7));
                    ln.end_y = ln.start_y ^ t_coord'($urandom_range(0, 7));
                end
                default: ;
            endcase
            send_line(ln, 1'b0, none);
            if ($urandom_range(0, 19) == 0) wait_drained();
        end
        line_ch.valid <= 1'b0;

        while (plot_q.size() != 0) @(posedge i_clk);
        waited = 0;
        while (waited < DRAIN_CYC) begin
            @(posedge i_clk);
            waited++;
        end

        if (fails == 0 && plot_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
